>>> hw/rtl/hsal_pkg.sv
// ----------------------------------------------------------------------------
// hsal_pkg
// Types and constants shared by the hourly sensor average logger, its stream
// interfaces and its checker.
// ----------------------------------------------------------------------------
package hsal_pkg;

  // One sensor sample as it arrives on the input channel.
  typedef struct packed {
    logic [5:0]         minute;
    logic [15:0]        hour_count;
    logic [12:0]        co2_ppm;
    logic signed [11:0] temperature;
    logic [6:0]         humidity;
    logic [9:0]         pressure_mmhg;
  } sample_t;

  // One hourly record as it leaves on the output channel.
  typedef struct packed {
    logic [7:0] record_slot;
    logic [7:0] co2_code;
    logic [7:0] temperature_code;
    logic [6:0] humidity_code;
    logic [7:0] pressure_code;
  } record_t;

  // One entry of the sliding sample window (42 bits).
  typedef struct packed {
    logic [12:0]        co2;
    logic signed [11:0] temp;
    logic [6:0]         hum;
    logic [9:0]         press;
  } win_entry_t;

  // Minute value that marks "no minute seen yet".
  localparam logic [5:0] NoMinute = 6'd63;

  // Quantization constants. Temperature constants are in sixteenths of a
  // degree: 10 degrees is 160, a span of 30 degrees is 480.
  localparam int Co2Base    = 410;
  localparam int Co2Step    = 18;
  localparam int TempBase16 = 160;
  localparam int TempSpan16 = 480;
  localparam int TempScale  = 255;
  localparam int CodeMax    = 255;
  localparam int HumMax     = 100;
  localparam int PressBase  = 700;

endpackage

>>> hw/rtl/hsal_if.sv
// ----------------------------------------------------------------------------
// hsal_if
// Valid/ready stream interfaces for the sample input and record output.
// ----------------------------------------------------------------------------

// Sample channel: one beat carries one sensor sample.
interface hsal_sample_if;
  logic             valid;
  logic             ready;
  hsal_pkg::sample_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Record channel: one beat carries one quantized hourly record.
interface hsal_record_if;
  logic             valid;
  logic             ready;
  hsal_pkg::record_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/hourly_sensor_average_logger.sv
// ----------------------------------------------------------------------------
// hourly_sensor_average_logger
// Windows sensor samples and emits one quantized average record per hour.
// ----------------------------------------------------------------------------
// Usage:
// Samples arrive on sample_i, one beat per sample, tagged with the minute
// and an hour count. A beat whose minute repeats the last accepted minute is
// taken and dropped. A beat that does not close an hour is windowed in the
// cycle it is accepted, so such beats can be taken every cycle while idle.
// A beat whose hour count is above the stored hour, with a non-empty window,
// closes the hour: sample_i.ready drops while one shared restoring divider,
// one quotient bit per cycle, works out the five quotients in turn. The
// record is registered onto record_o once the last quotient is done.
// record_o is a registered output. The block returns to accepting samples
// while a record waits; if the next record is finished before the receiver
// takes the previous one, the block holds it and stays busy until then.
// Reset empties the window, clears the stored hour and ring slot, and marks
// no minute as seen. The window storage itself is not cleared.
// ----------------------------------------------------------------------------
module hourly_sensor_average_logger #(
  parameter int WINDOW_DEPTH = 6,
  parameter int RECORD_SLOTS = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  hsal_sample_if.sink   sample_i,
  hsal_record_if.source record_o
);
  import hsal_pkg::*;

  localparam int CntW      = $clog2(WINDOW_DEPTH + 1);
  localparam int PtrW      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int Co2SumW   = 13 + CntW;
  localparam int TempSumW  = 12 + CntW;
  localparam int HumSumW   = 7 + CntW;
  localparam int PressSumW = 10 + CntW;
  localparam int NumW      = TempSumW + 9;
  localparam int DivW      = NumW - 1;
  localparam int DvsW      = $clog2(TempSpan16 * WINDOW_DEPTH + 1);
  localparam int BitW      = $clog2(DivW + 1);

  // Sequencer states.
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSum  = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  // Divider operations, run in this order.
  localparam logic [2:0] OpCo2Avg  = 3'd0;
  localparam logic [2:0] OpCo2Code = 3'd1;
  localparam logic [2:0] OpTemp    = 3'd2;
  localparam logic [2:0] OpHum     = 3'd3;
  localparam logic [2:0] OpPress   = 3'd4;

  logic [1:0]               state_q, state_d;
  logic [2:0]               op_q, op_d;
  logic                     load_q, load_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [PtrW-1:0]          ptr_q, ptr_d;
  logic [5:0]               last_min_q, last_min_d;
  logic [15:0]              hour_q, hour_d;
  logic [7:0]               slot_q, slot_d;
  logic [CntW-1:0]          idx_q, idx_d;
  logic [CntW-1:0]          n_q, n_d;
  win_entry_t               pend_q, pend_d;
  logic [Co2SumW-1:0]       co2_sum_q, co2_sum_d;
  logic signed [TempSumW-1:0] temp_sum_q, temp_sum_d;
  logic [HumSumW-1:0]       hum_sum_q, hum_sum_d;
  logic [PressSumW-1:0]     press_sum_q, press_sum_d;
  logic [DvsW-1:0]          rem_q, rem_d;
  logic [DivW-1:0]          quo_q, quo_d;
  logic [DvsW-1:0]          dvs_q, dvs_d;
  logic [BitW-1:0]          bits_q, bits_d;
  logic [7:0]               co2_code_q, co2_code_d;
  logic [7:0]               temp_code_q, temp_code_d;
  logic [6:0]               hum_code_q, hum_code_d;
  logic [7:0]               press_code_q, press_code_d;
  logic                     out_valid_q, out_valid_d;
  record_t                  out_q, out_d;

  win_entry_t               win_q [WINDOW_DEPTH];
  logic                     win_we;
  logic [PtrW-1:0]          win_wa;
  win_entry_t               win_wd;
  win_entry_t               win_rd;

  logic                     accept;
  logic                     drop;
  logic                     hour_adv;
  logic [CntW-1:0]          base_cnt;
  win_entry_t               in_entry;

  logic [12:0]              co2_avg;
  logic [12:0]              co2_off;
  logic [TempSumW:0]        temp_ofs;
  logic signed [TempSumW:0] temp_diff;
  logic signed [NumW-1:0]   temp_num;
  logic [DvsW:0]            div_shl;
  logic                     div_ge;
  logic [DvsW:0]            div_sub;
  logic [DivW-1:0]          press_diff;
  logic [8:0]               slot_inc;

  // Input handshake and sample classification.
  assign sample_i.ready = (state_q == StIdle);
  assign accept   = sample_i.valid && sample_i.ready;
  assign drop     = (sample_i.data.minute == last_min_q);
  assign hour_adv = (sample_i.data.hour_count > hour_q);
  assign base_cnt = hour_adv ? '0 : cnt_q;
  assign in_entry = '{co2:   sample_i.data.co2_ppm,
                      temp:  sample_i.data.temperature,
                      hum:   sample_i.data.humidity,
                      press: sample_i.data.pressure_mmhg};

  // Window read port, stepped by the summing index.
  assign win_rd = win_q[idx_q[PtrW-1:0]];

  // Operand preparation for the divider loads.
  assign co2_avg   = quo_q[12:0];
  assign co2_off   = (co2_avg >= 13'(Co2Base)) ? co2_avg - 13'(Co2Base) : '0;
  assign temp_ofs  = (TempSumW + 1)'(n_q) * (TempSumW + 1)'(TempBase16);
  assign temp_diff = $signed({temp_sum_q[TempSumW-1], temp_sum_q}) - $signed(temp_ofs);
  assign temp_num  = (NumW'(temp_diff) <<< 8) - NumW'(temp_diff);

  // One restoring division step: shift in a dividend bit, trial subtract.
  assign div_shl = {rem_q, quo_q[DivW-1]};
  assign div_ge  = (div_shl >= {1'b0, dvs_q});
  assign div_sub = div_shl - {1'b0, dvs_q};

  assign press_diff = quo_q - DivW'(PressBase);
  assign slot_inc   = {1'b0, slot_q} + 9'd1;

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    load_d       = load_q;
    cnt_d        = cnt_q;
    ptr_d        = ptr_q;
    last_min_d   = last_min_q;
    hour_d       = hour_q;
    slot_d       = slot_q;
    idx_d        = idx_q;
    n_d          = n_q;
    pend_d       = pend_q;
    co2_sum_d    = co2_sum_q;
    temp_sum_d   = temp_sum_q;
    hum_sum_d    = hum_sum_q;
    press_sum_d  = press_sum_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    dvs_d        = dvs_q;
    bits_d       = bits_q;
    co2_code_d   = co2_code_q;
    temp_code_d  = temp_code_q;
    hum_code_d   = hum_code_q;
    press_code_d = press_code_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    win_we       = 1'b0;
    win_wa       = '0;
    win_wd       = in_entry;

    // The receiver taking the held record frees the output register.
    if (out_valid_q && record_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (accept && !drop) begin
          last_min_d = sample_i.data.minute;
          if (hour_adv) begin
            hour_d = sample_i.data.hour_count;
          end
          if (hour_adv && (cnt_q != '0)) begin
            // Close the hour: sum the old window before the sample enters.
            state_d     = StSum;
            n_d         = cnt_q;
            idx_d       = '0;
            pend_d      = in_entry;
            co2_sum_d   = '0;
            temp_sum_d  = '0;
            hum_sum_d   = '0;
            press_sum_d = '0;
          end else begin
            win_we = 1'b1;
            win_wa = hour_adv ? '0 : ptr_q;
            ptr_d  = (win_wa == PtrW'(WINDOW_DEPTH - 1)) ? '0 : win_wa + 1'b1;
            cnt_d  = (base_cnt == CntW'(WINDOW_DEPTH)) ? base_cnt : base_cnt + 1'b1;
          end
        end
      end

      StSum: begin
        co2_sum_d   = co2_sum_q + Co2SumW'(win_rd.co2);
        temp_sum_d  = temp_sum_q + TempSumW'(win_rd.temp);
        hum_sum_d   = hum_sum_q + HumSumW'(win_rd.hum);
        press_sum_d = press_sum_q + PressSumW'(win_rd.press);
        idx_d       = idx_q + 1'b1;
        if ((idx_q + 1'b1) == n_q) begin
          // Window restarts with the pending sample alone.
          win_we  = 1'b1;
          win_wa  = '0;
          win_wd  = pend_q;
          ptr_d   = (PtrW'(0) == PtrW'(WINDOW_DEPTH - 1)) ? '0 : PtrW'(1);
          cnt_d   = CntW'(1);
          state_d = StDiv;
          op_d    = OpCo2Avg;
          load_d  = 1'b1;
        end
      end

      StDiv: begin
        if (load_q) begin
          // Load the dividend left-aligned so its width sets the step count.
          load_d = 1'b0;
          rem_d  = '0;
          case (op_q)
            OpCo2Avg: begin
              quo_d  = {co2_sum_q, {(DivW - Co2SumW){1'b0}}};
              dvs_d  = DvsW'(n_q);
              bits_d = BitW'(Co2SumW);
            end
            OpCo2Code: begin
              quo_d  = {co2_off, {(DivW - 13){1'b0}}};
              dvs_d  = DvsW'(Co2Step);
              bits_d = BitW'(13);
            end
            OpTemp: begin
              quo_d  = temp_num[NumW-1] ? '0 : temp_num[DivW-1:0];
              dvs_d  = DvsW'(n_q) * DvsW'(TempSpan16);
              bits_d = BitW'(DivW);
            end
            OpHum: begin
              quo_d  = {hum_sum_q, {(DivW - HumSumW){1'b0}}};
              dvs_d  = DvsW'(n_q);
              bits_d = BitW'(HumSumW);
            end
            default: begin
              quo_d  = {press_sum_q, {(DivW - PressSumW){1'b0}}};
              dvs_d  = DvsW'(n_q);
              bits_d = BitW'(PressSumW);
            end
          endcase
        end else if (bits_q != '0) begin
          rem_d  = div_ge ? div_sub[DvsW-1:0] : div_shl[DvsW-1:0];
          quo_d  = {quo_q[DivW-2:0], div_ge};
          bits_d = bits_q - 1'b1;
        end else begin
          // Quotient done: saturate any code; then the next op, or output.
          load_d = 1'b1;
          case (op_q)
            OpCo2Avg: begin
              op_d = OpCo2Code;
            end
            OpCo2Code: begin
              co2_code_d = (quo_q > DivW'(CodeMax)) ? 8'(CodeMax) : quo_q[7:0];
              op_d       = OpTemp;
            end
            OpTemp: begin
              temp_code_d = (quo_q > DivW'(CodeMax)) ? 8'(CodeMax) : quo_q[7:0];
              op_d        = OpHum;
            end
            OpHum: begin
              hum_code_d = (quo_q > DivW'(HumMax)) ? 7'(HumMax) : quo_q[6:0];
              op_d       = OpPress;
            end
            default: begin
              load_d = 1'b0;
              if (quo_q < DivW'(PressBase)) begin
                press_code_d = '0;
              end else if (press_diff > DivW'(CodeMax)) begin
                press_code_d = 8'(CodeMax);
              end else begin
                press_code_d = press_diff[7:0];
              end
              state_d = StOut;
            end
          endcase
        end
      end

      default: begin
        // Hand the record over once the output register is free.
        if (!out_valid_q || record_o.ready) begin
          out_valid_d            = 1'b1;
          out_d.record_slot      = slot_q;
          out_d.co2_code         = co2_code_q;
          out_d.temperature_code = temp_code_q;
          out_d.humidity_code    = hum_code_q;
          out_d.pressure_code    = press_code_q;
          slot_d  = (slot_inc >= 9'(RECORD_SLOTS)) ? '0 : slot_inc[7:0];
          state_d = StIdle;
        end
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      op_q        <= OpCo2Avg;
      load_q      <= 1'b0;
      cnt_q       <= '0;
      ptr_q       <= '0;
      last_min_q  <= NoMinute;
      hour_q      <= '0;
      slot_q      <= '0;
      idx_q       <= '0;
      n_q         <= '0;
      bits_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      load_q      <= load_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      last_min_q  <= last_min_d;
      hour_q      <= hour_d;
      slot_q      <= slot_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      bits_q      <= bits_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pend_q       <= pend_d;
    co2_sum_q    <= co2_sum_d;
    temp_sum_q   <= temp_sum_d;
    hum_sum_q    <= hum_sum_d;
    press_sum_q  <= press_sum_d;
    rem_q        <= rem_d;
    quo_q        <= quo_d;
    dvs_q        <= dvs_d;
    co2_code_q   <= co2_code_d;
    temp_code_q  <= temp_code_d;
    hum_code_q   <= hum_code_d;
    press_code_q <= press_code_d;
    out_q        <= out_d;
  end

  // Sample window storage.
  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_q[win_wa] <= win_wd;
    end
  end

  assign record_o.valid = out_valid_q;
  assign record_o.data  = out_q;

endmodule

>>> hw/rtl/hsal_checker.sv
// ----------------------------------------------------------------------------
// hsal_checker
// Port-level checks on the record channel of the hourly average logger.
// ----------------------------------------------------------------------------
module hsal_checker #(
  parameter int RECORD_SLOTS = 128
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input hsal_pkg::record_t out_data_i
);
  import hsal_pkg::*;

  logic       seen_q;
  logic [7:0] exp_slot_q;
  logic [8:0] slot_inc;

  assign slot_inc = {1'b0, out_data_i.record_slot} + 9'd1;

  // Track the ring slot the next record must carry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      exp_slot_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      seen_q     <= 1'b1;
      exp_slot_q <= (slot_inc >= 9'(RECORD_SLOTS)) ? '0 : slot_inc[7:0];
    end
  end

  // A stalled record beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("record beat changed while stalled");

  // Records fill the ring slots in order, wrapping at the ring size.
  a_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && seen_q |-> out_data_i.record_slot == exp_slot_q)
    else $error("record slot out of sequence");

  // The slot never leaves the ring.
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> {1'b0, out_data_i.record_slot} < 9'(RECORD_SLOTS))
    else $error("record slot beyond ring size");

  // Humidity is saturated to whole percent.
  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.humidity_code <= 7'(HumMax))
    else $error("humidity code above saturation");

endmodule

bind hourly_sensor_average_logger hsal_checker #(
  .RECORD_SLOTS(RECORD_SLOTS)
) u_hsal_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (record_o.valid),
  .out_ready_i (record_o.ready),
  .out_data_i  (record_o.data)
);

>>> tb/hsal_average_checker.sv
// ----------------------------------------------------------------------------
// hsal_average_checker
// Watches the sample and record channels of the hourly sensor average logger.
// It keeps its own copy of the sample window, the minute and hour marks and
// the ring slot, and works out the record that each closing sample should
// bring. Records leaving the block are compared in order with those waiting.
// ----------------------------------------------------------------------------
module hsal_average_checker
  import hsal_pkg::*;
#(
  parameter int WINDOW_DEPTH = 6,
  parameter int RECORD_SLOTS = 128
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  hsal_sample_if sample_mon,
  hsal_record_if record_mon,
  output int     mismatch_count_o,
  output int     pending_records_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ReportLimit = 10;

  // Predicted state of the logger.
  win_entry_t  window_q [WINDOW_DEPTH];
  int unsigned window_fill;
  logic [5:0]  prev_minute;
  logic [15:0] hour_mark;
  int unsigned next_slot;

  // Records predicted but not yet seen on the output.
  record_t     hour_record_q [$];
  int          mismatches;

  function automatic logic [7:0] clamp_code(longint value, longint top_code);
    if (value < 0) return 8'd0;
    if (value > top_code) return 8'(top_code);
    return 8'(value);
  endfunction

  // Averages the current window into one quantized record.
  function automatic record_t average_window();
    longint  sum_co2;
    longint  sum_temp;
    longint  sum_hum;
    longint  sum_press;
    longint  n;
    record_t rec;
    sum_co2   = 0;
    sum_temp  = 0;
    sum_hum   = 0;
    sum_press = 0;
    n         = longint'(window_fill);
    for (int i = 0; i < window_fill; i++) begin
      sum_co2   += longint'(window_q[i].co2);
      sum_temp  += longint'(window_q[i].temp);
      sum_hum   += longint'(window_q[i].hum);
      sum_press += longint'(window_q[i].press);
    end
    rec.record_slot      = 8'(next_slot);
    rec.co2_code         = clamp_code((sum_co2 / n - Co2Base) / Co2Step, CodeMax);
    rec.temperature_code = clamp_code(((sum_temp - TempBase16 * n) * TempScale) /
                                      (TempSpan16 * n), CodeMax);
    rec.humidity_code    = 7'(clamp_code(sum_hum / n, HumMax));
    rec.pressure_code    = clamp_code(sum_press / n - PressBase, CodeMax);
    return rec;
  endfunction

  // Applies one accepted sample beat to the predicted state.
  task automatic take_sample(input sample_t s);
    win_entry_t entry;
    entry.co2   = s.co2_ppm;
    entry.temp  = s.temperature;
    entry.hum   = s.humidity;
    entry.press = s.pressure_mmhg;
    // A repeated minute leaves everything as it was.
    if (s.minute == prev_minute) return;
    // A later hour closes the current one; an empty window gives no record.
    if (s.hour_count > hour_mark) begin
      if (window_fill > 0) begin
        hour_record_q.push_back(average_window());
        next_slot = (next_slot + 1 >= RECORD_SLOTS) ? 0 : next_slot + 1;
      end
      window_fill = 0;
      hour_mark   = s.hour_count;
    end
    prev_minute = s.minute;
    // Slide the window once it is full.
    if (window_fill < WINDOW_DEPTH) begin
      window_q[window_fill] = entry;
      window_fill++;
    end else begin
      for (int i = 0; i < WINDOW_DEPTH - 1; i++) window_q[i] = window_q[i + 1];
      window_q[WINDOW_DEPTH - 1] = entry;
    end
  endtask

  // Compares one record beat with the oldest prediction.
  task automatic check_record(input record_t got);
    record_t want;
    if (hour_record_q.size() == 0) begin
      mismatches++;
      if (mismatches <= ReportLimit) begin
        $display("%0t: record beat with none predicted: slot %0d codes %0d %0d %0d %0d",
                 $realtime, got.record_slot, got.co2_code, got.temperature_code,
                 got.humidity_code, got.pressure_code);
      end
      return;
    end
    want = hour_record_q.pop_front();
    if (got.record_slot !== want.record_slot || got.co2_code !== want.co2_code ||
        got.temperature_code !== want.temperature_code ||
        got.humidity_code !== want.humidity_code ||
        got.pressure_code !== want.pressure_code) begin
      mismatches++;
      if (mismatches <= ReportLimit) begin
        $display("%0t: record mismatch (expected/actual) slot %0d/%0d co2 %0d/%0d",
                 $realtime, want.record_slot, got.record_slot, want.co2_code,
                 got.co2_code);
        $display("    temperature %0d/%0d humidity %0d/%0d pressure %0d/%0d",
                 want.temperature_code, got.temperature_code, want.humidity_code,
                 got.humidity_code, want.pressure_code, got.pressure_code);
      end
    end
  endtask

  // The record side is checked before the sample side: a sample taken in the
  // same cycle can never be the cause of that record.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_fill = 0;
      prev_minute = NoMinute;
      hour_mark   = '0;
      next_slot   = 0;
      mismatches  = 0;
      hour_record_q.delete();
      pending_records_o <= 0;
      mismatch_count_o  <= 0;
    end else begin
      if (record_mon.valid && record_mon.ready) check_record(record_mon.data);
      if (sample_mon.valid && sample_mon.ready) take_sample(sample_mon.data);
      pending_records_o <= hour_record_q.size();
      mismatch_count_o  <= mismatches;
    end
  end

endmodule

>>> tb/hourly_sensor_average_logger_tb.sv
// ----------------------------------------------------------------------------
// hourly_sensor_average_logger_tb
// Drives sensor samples into the hourly sensor average logger: a directed
// run over the field extremes and corner cases, then random hours of samples
// mixed with repeated minutes and stale hours. The sender works in bursts and
// the receiver stalls in changing patterns, with one long hold-off. The
// checker beside the block predicts and compares every record.
// ----------------------------------------------------------------------------
module hourly_sensor_average_logger_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsal_pkg::*;

  localparam int WindowDepth  = 6;
  localparam int RecordSlots  = 128;
  localparam int SampleTarget = 1950;
  localparam int IdleLimit    = 4000;
  localparam int LongHold     = 1200;
  localparam int DrainCycles  = 200;

  logic clk_i;
  logic rst_ni;

  hsal_sample_if sample_if ();
  hsal_record_if record_if ();

  int         mismatch_total;
  int         pending_records;
  bit         hold_request;
  bit         offering;
  int         burst_left;
  int         kept_samples;
  logic [5:0] sent_minute;
  int         idle_cycles;

  hourly_sensor_average_logger #(
    .WINDOW_DEPTH(WindowDepth),
    .RECORD_SLOTS(RecordSlots)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_if),
    .record_o(record_if)
  );

  hsal_average_checker #(
    .WINDOW_DEPTH(WindowDepth),
    .RECORD_SLOTS(RecordSlots)
  ) checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sample_mon       (sample_if),
    .record_mon       (record_if),
    .mismatch_count_o (mismatch_total),
    .pending_records_o(pending_records)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic sample_t pack_sample(int min_v, int hour_v, int co2, int temp,
                                          int hum, int press);
    sample_t s;
    s.minute        = 6'(min_v);
    s.hour_count    = 16'(hour_v);
    s.co2_ppm       = 13'(co2);
    s.temperature   = 12'(temp);
    s.humidity      = 7'(hum);
    s.pressure_mmhg = 10'(press);
    return s;
  endfunction

  // Random content: wide covers every field code, narrow keeps each field in a
  // span around its code range, so some codes still clamp.
  function automatic sample_t make_sample(logic [5:0] min_v, logic [15:0] hour_v, bit wide);
    sample_t s;
    int      temp;
    temp = int'($urandom_range(0, 2000)) - 640;
    s.minute     = min_v;
    s.hour_count = hour_v;
    if (wide) begin
      s.co2_ppm       = 13'($urandom);
      s.temperature   = 12'($urandom);
      s.humidity      = 7'($urandom);
      s.pressure_mmhg = 10'($urandom);
    end else begin
      s.co2_ppm       = 13'($urandom_range(380, 5000));
      s.temperature   = 12'(temp);
      s.humidity      = 7'($urandom_range(0, 100));
      s.pressure_mmhg = 10'($urandom_range(690, 980));
    end
    return s;
  endfunction

  // Offers one sample beat until an edge takes it. A burst that ends there is
  // followed by a random gap.
  task automatic offer(input sample_t s);
    sample_if.valid <= 1'b1;
    sample_if.data  <= s;
    offering = 1'b1;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    if (s.minute != sent_minute) begin
      kept_samples++;
      sent_minute = s.minute;
    end
    burst_left--;
    if (burst_left <= 0) begin
      sample_if.valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24);
    end
  endtask

  // Stops offering and waits until every predicted record has left.
  task automatic pause_until_drained();
    if (offering) begin
      sample_if.valid <= 1'b0;
      offering = 1'b0;
    end
    @(posedge clk_i);
    wait (pending_records == 0);
  endtask

  // One hour of samples: the first closes the previous hour, the rest fill
  // the window, with stray beats mixed in.
  task automatic send_hour_block(input logic [15:0] hour_v, input int len, input bit wide);
    logic [5:0] min_v;
    sample_t    stray;
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 2))
          // Repeated minute: dropped whatever the hour says.
          0: stray = make_sample(sent_minute, 16'($urandom), 1'b1);
          // Any minute code with an hour no later than the current one.
          1: stray = make_sample(6'($urandom), 16'($urandom_range(0, hour_v)), 1'b1);
          default: begin
            stray = make_sample(6'($urandom_range(0, 59)),
                                16'($urandom_range(0, hour_v)), 1'b0);
          end
        endcase
        offer(stray);
      end
      min_v = 6'((sent_minute + 1 + $urandom_range(0, 2)) % 60);
      offer(make_sample(min_v, hour_v, wide));
    end
  endtask

  // Receiver: stall patterns that change after a random span, and one
  // long hold-off on request.
  initial begin : record_sink
    int mode;
    int span;
    int phase;
    record_if.ready = 1'b0;
    phase = 0;
    wait (rst_ni === 1'b1);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 400);
      repeat (span) begin
        @(posedge clk_i);
        phase++;
        if (hold_request) begin
          hold_request = 1'b0;
          record_if.ready <= 1'b0;
          repeat (LongHold) @(posedge clk_i);
        end else begin
          case (mode)
            0:       record_if.ready <= 1'b1;
            1:       record_if.ready <= 1'($urandom_range(0, 1));
            2:       record_if.ready <= (phase % 3 != 0);
            default: record_if.ready <= ($urandom_range(0, 15) == 0);
          endcase
        end
      end
    end
  end

  // Watchdog: ends the run when no beat moves for too long.
  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((sample_if.valid && sample_if.ready) || (record_if.valid && record_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("hourly_sensor_average_logger_tb: errors");
    $finish;
  end

  initial begin : stimulus
    int cur_hour;
    int len;
    bit held;
    bit paused;
    bit jumped;
    sample_if.valid = 1'b0;
    sample_if.data  = '0;
    rst_ni          = 1'b0;
    hold_request    = 1'b0;
    offering        = 1'b0;
    burst_left      = 10;
    kept_samples    = 0;
    sent_minute     = NoMinute;
    held            = 1'b0;
    paused          = 1'b0;
    jumped          = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    // Minute 63 straight after reset matches the no-minute mark and is dropped.
    offer(pack_sample(63, 3, 100, 0, 50, 750));
    // Hour advance while the window is still empty.
    offer(pack_sample(0, 1, 0, -2048, 0, 0));
    // Repeated minute carrying a new hour.
    offer(pack_sample(0, 2, 900, 100, 30, 800));
    // Same hour, then an hour below the stored one.
    offer(pack_sample(1, 1, 8191, 2047, 127, 1023));
    offer(pack_sample(2, 0, 500, 320, 40, 760));
    // Fill the window and push the oldest samples out.
    for (int m = 3; m < 8; m++) begin
      offer(pack_sample(m, 1, 400 + 150 * m, 96 * m, 10 * m, 690 + 20 * m));
    end
    // Close a mixed hour, then build a window of top readings.
    offer(pack_sample(8, 2, 8191, 2047, 127, 1023));
    for (int m = 9; m < 13; m++) offer(pack_sample(m, 2, 8191, 2047, 127, 1023));
    // Codes saturate high; then a window of bottom readings.
    offer(pack_sample(13, 3, 0, -2048, 0, 0));
    for (int m = 14; m < 17; m++) offer(pack_sample(m, 3, 0, -2048, 0, 0));
    // Codes clamp to zero.
    offer(pack_sample(17, 4, 428, 640, 100, 955));
    offer(pack_sample(18, 4, 5000, 400, 55, 860));
    offer(pack_sample(59, 5, 1000, 300, 45, 740));
    offer(pack_sample(59, 6, 2000, 500, 60, 900));

    // Random part.
    cur_hour = 5;
    while (kept_samples < SampleTarget) begin
      if (!held && kept_samples >= SampleTarget / 4) begin
        // Short hours while the receiver holds off fill the block up.
        held         = 1'b1;
        hold_request = 1'b1;
        repeat (8) begin
          cur_hour++;
          send_hour_block(16'(cur_hour), $urandom_range(1, 2), 1'($urandom_range(0, 1)));
        end
      end else if (!paused && kept_samples >= (SampleTarget * 3) / 4) begin
        paused = 1'b1;
        pause_until_drained();
      end else begin
        if (!jumped && kept_samples >= SampleTarget / 2) begin
          jumped   = 1'b1;
          cur_hour = 16'h8000 + $urandom_range(0, 16'h3FFF);
        end else if ($urandom_range(0, 15) == 0) begin
          cur_hour += $urandom_range(2, 300);
        end else begin
          cur_hour++;
        end
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        send_hour_block(16'(cur_hour), len, $urandom_range(0, 2) == 0);
      end
    end
    // The last hour code there is.
    send_hour_block(16'hFFFF, 3, 1'b1);

    pause_until_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_total == 0) begin
      $display("hourly_sensor_average_logger_tb: clean");
    end else begin
      $display("hourly_sensor_average_logger_tb: errors");
    end
    $finish;
  end

endmodule

>>> hourly_sensor_average_logger.f
hw/rtl/hsal_pkg.sv
hw/rtl/hsal_if.sv
hw/rtl/hourly_sensor_average_logger.sv
hw/rtl/hsal_checker.sv
tb/hsal_average_checker.sv
tb/hourly_sensor_average_logger_tb.sv
